// ===== hdl/kwsrm_pkg.sv =====
`default_nettype none
package kwsrm_pkg;
    localparam int RUNS   = 16;
    localparam int RUN_W  = $clog2(RUNS);
    localparam int CNT_W  = $clog2(RUNS + 1);
    localparam int WORD_W = 64;
    localparam int IDX_W  = 4;
    localparam int CFG_W  = 5;
endpackage
`default_nettype wire

// ===== hdl/k_way_sorted_run_merger.sv =====
// A word result passes from IDLE through CHECK, SCAN and EMIT into the output
// register; a done result goes from CHECK straight to EMIT. An output stall holds EMIT.
// The input stalls outside IDLE, so no item is taken while the last is in work;
// word results are paced by the serial minimum scan over the single read port.
// Reset (synchronous, active low): full and finished marks cleared, run count 16.
// Head words are not cleared; they are used only while their full mark is set.
`default_nettype none
module k_way_sorted_run_merger (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // config
    input  wire logic                          i_cfg_we,
    input  wire logic [kwsrm_pkg::CFG_W-1:0]   i_cfg_data,
    // input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [kwsrm_pkg::IDX_W-1:0]   i_run_index,
    input  wire logic [kwsrm_pkg::WORD_W-1:0]  i_word_value,
    input  wire logic                          i_run_end,
    // output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [kwsrm_pkg::WORD_W-1:0]       o_min_value,
    output logic [kwsrm_pkg::IDX_W-1:0]        o_source_run,
    output logic                               o_merge_done
);
    // Control sequence:
    //   IDLE  - take one item; flags and head memory update at the transfer edge
    //   CHECK - look at the registered flags, decide word / done / nothing
    //   SCAN  - walk the head memory one read per cycle, keeping the smallest
    //           full head (strict less-than, so the lowest run wins a tie)
    //   EMIT  - wait for the output register, load the result, clear the head of a word result
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_SCAN  = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [kwsrm_pkg::CFG_W-1:0]  r_run_count;
    logic [kwsrm_pkg::RUNS-1:0]   r_full;
    logic [kwsrm_pkg::RUNS-1:0]   r_fin;
    logic                         r_end_taken;
    logic                         r_is_done;

    // head word store, one synchronous read port
    logic [kwsrm_pkg::WORD_W-1:0] r_mem [kwsrm_pkg::RUNS];
    logic [kwsrm_pkg::WORD_W-1:0] r_rd_data;
    logic [kwsrm_pkg::RUN_W-1:0]  r_rd_idx;
    logic                         r_rd_vld;

    // scan control
    logic [kwsrm_pkg::RUN_W-1:0]  r_scan_addr;
    logic                         r_issue_on;
    logic                         r_have;
    logic [kwsrm_pkg::WORD_W-1:0] r_best_val;
    logic [kwsrm_pkg::RUN_W-1:0]  r_best_idx;

    // output register
    logic                         r_out_valid;
    logic [kwsrm_pkg::WORD_W-1:0] r_out_value;
    logic [kwsrm_pkg::IDX_W-1:0]  r_out_src;
    logic                         r_out_done;

    logic [kwsrm_pkg::CNT_W-1:0]  w_n;
    logic [kwsrm_pkg::RUN_W-1:0]  w_last;
    logic [kwsrm_pkg::RUN_W-1:0]  w_idx;
    logic                         w_in_xfer;
    logic                         w_take;
    logic                         w_out_free;
    logic                         w_all_ready;
    logic                         w_any_full;
    logic                         w_all_fin;
    logic                         w_better;

    // active run count: zero acts as one, above RUNS saturates
    always_comb begin
        if (r_run_count == '0) begin
            w_n = kwsrm_pkg::CNT_W'(1);
        end else if (32'(r_run_count) > 32'(kwsrm_pkg::RUNS)) begin
            w_n = kwsrm_pkg::CNT_W'(kwsrm_pkg::RUNS);
        end else begin
            w_n = kwsrm_pkg::CNT_W'(r_run_count);
        end
    end
    assign w_last = kwsrm_pkg::RUN_W'(w_n - kwsrm_pkg::CNT_W'(1));

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_idx      = kwsrm_pkg::RUN_W'(i_run_index);
    // item counts only for an active run that is neither full nor finished
    assign w_take     = w_in_xfer && (32'(i_run_index) < 32'(w_n))
                        && !r_full[w_idx] && !r_fin[w_idx];
    assign w_out_free = !r_out_valid || !i_out_stall;

    // readiness over the active runs only
    always_comb begin
        w_all_ready = 1'b1;
        w_any_full  = 1'b0;
        w_all_fin   = 1'b1;
        for (int i = 0; i < kwsrm_pkg::RUNS; i++) begin
            if (32'(i) < 32'(w_n)) begin
                if (r_full[i]) begin
                    w_any_full = 1'b1;
                    w_all_fin  = 1'b0;
                end else if (!r_fin[i]) begin
                    w_all_ready = 1'b0;
                    w_all_fin   = 1'b0;
                end
            end
        end
    end

    assign w_better = r_rd_vld && r_full[r_rd_idx] && (!r_have || (r_rd_data < r_best_val));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_all_ready && w_any_full) begin
                    n_state = S_SCAN;
                end else if (r_end_taken && w_all_fin) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (r_rd_vld && !r_issue_on) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // head memory: write on a taken word, read during the scan
    always_ff @(posedge i_clk) begin
        if (w_take && !i_run_end) begin
            r_mem[w_idx] <= i_word_value;
        end
        r_rd_data <= r_mem[r_scan_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run_count <= kwsrm_pkg::CFG_W'(16);
            r_full      <= '0;
            r_fin       <= '0;
            r_end_taken <= 1'b0;
            r_is_done   <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_issue_on  <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_run_count <= i_cfg_data;
            // load on emit, drop once the pending result is taken
            if (r_state == S_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_end_taken <= w_take && i_run_end;
                        if (w_take) begin
                            if (i_run_end) r_fin[w_idx]  <= 1'b1;
                            else           r_full[w_idx] <= 1'b1;
                        end
                    end
                end
                S_CHECK: begin
                    r_is_done   <= !(w_all_ready && w_any_full);
                    r_issue_on  <= 1'b1;
                    r_rd_vld    <= 1'b0;
                    r_have      <= 1'b0;
                end
                S_SCAN: begin
                    r_rd_vld <= r_issue_on;
                    if (r_issue_on && r_scan_addr == w_last) r_issue_on <= 1'b0;
                    if (w_better) r_have <= 1'b1;
                end
                S_EMIT: begin
                    if (w_out_free && !r_is_done) r_full[r_best_idx] <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // payload and scan datapath, no reset
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_CHECK: begin
                r_scan_addr <= '0;
            end
            S_SCAN: begin
                r_rd_idx <= r_scan_addr;
                if (r_issue_on && r_scan_addr != w_last) begin
                    r_scan_addr <= r_scan_addr + kwsrm_pkg::RUN_W'(1);
                end
                if (w_better) begin
                    r_best_val <= r_rd_data;
                    r_best_idx <= r_rd_idx;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    if (r_is_done) begin
                        r_out_value <= '0;
                        r_out_src   <= '0;
                        r_out_done  <= 1'b1;
                    end else begin
                        r_out_value <= r_best_val;
                        r_out_src   <= kwsrm_pkg::IDX_W'(r_best_idx);
                        r_out_done  <= 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_min_value  = r_out_value;
    assign o_source_run = r_out_src;
    assign o_merge_done = r_out_done;
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import kwsrm_pkg::*;

    // Time to let the block return to idle after a transfer that yields no
    // result, before a config write.
    localparam int SETTLE_CYCLES = RUNS + 8;
    localparam int RUN_LIMIT_NS  = 3_000_000;
    localparam int PRINT_CAP     = 100;
    localparam logic [WORD_W-1:0] WORD_MAX = {WORD_W{1'b1}};

    typedef enum logic [0:0] {ROW_CFG, ROW_ITEM} t_row_kind;
    // how a directed row is checked: by the predictor, or by a typed outcome
    typedef enum logic [1:0] {BY_MODEL, NO_RESULT, ONE_RESULT} t_row_check;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic [IDX_W-1:0]  src;
        logic              done;
    } t_merge_out;

    typedef struct packed {
        t_row_kind         kind;
        t_row_check        check;
        logic [CFG_W-1:0]  count;
        logic [IDX_W-1:0]  run;
        logic [WORD_W-1:0] word;
        logic              last;
        t_merge_out        due;
    } t_plan_row;

    localparam int PLAN_LEN = 20;
    localparam t_merge_out NO_OUT = '0;

    // Directed walk. One-run mode (count 0) with inactive runs ignored, then three
    // runs with ties, ignored transfers (full, finished) and the done result,
    // then the count saturated from 31 down to 16.
    localparam t_plan_row PLAN [PLAN_LEN] = '{
        '{ROW_CFG,  NO_RESULT,  5'd0,  4'd0,  64'd0,    1'b0, NO_OUT},
        '{ROW_ITEM, ONE_RESULT, 5'd0,  4'd0,  64'd0,    1'b0, '{64'd0, 4'd0, 1'b0}},
        '{ROW_ITEM, ONE_RESULT, 5'd0,  4'd0,  WORD_MAX, 1'b0, '{WORD_MAX, 4'd0, 1'b0}},
        '{ROW_ITEM, NO_RESULT,  5'd0,  4'd1,  64'd5,    1'b0, NO_OUT},
        '{ROW_ITEM, NO_RESULT,  5'd0,  4'd15, 64'd0,    1'b1, NO_OUT},
        '{ROW_CFG,  NO_RESULT,  5'd3,  4'd0,  64'd0,    1'b0, NO_OUT},
        '{ROW_ITEM, NO_RESULT,  5'd0,  4'd1,  64'd100,  1'b0, NO_OUT},
        '{ROW_ITEM, NO_RESULT,  5'd0,  4'd2,  64'd100,  1'b0, NO_OUT},
        '{ROW_ITEM, ONE_RESULT, 5'd0,  4'd0,  64'd100,  1'b0, '{64'd100, 4'd0, 1'b0}},
        '{ROW_ITEM, NO_RESULT,  5'd0,  4'd1,  64'd7,    1'b0, NO_OUT},
        '{ROW_ITEM, ONE_RESULT, 5'd0,  4'd0,  64'd0,    1'b1, '{64'd100, 4'd1, 1'b0}},
        '{ROW_ITEM, NO_RESULT,  5'd0,  4'd0,  64'd1,    1'b0, NO_OUT},
        '{ROW_ITEM, BY_MODEL,   5'd0,  4'd1,  WORD_MAX, 1'b0, NO_OUT},
        '{ROW_ITEM, BY_MODEL,   5'd0,  4'd2,  64'd0,    1'b0, NO_OUT},
        '{ROW_ITEM, BY_MODEL,   5'd0,  4'd2,  64'd0,    1'b1, NO_OUT},
        '{ROW_ITEM, ONE_RESULT, 5'd0,  4'd1,  64'd0,    1'b1, '{64'd0, 4'd0, 1'b1}},
        '{ROW_ITEM, NO_RESULT,  5'd0,  4'd1,  64'd9,    1'b0, NO_OUT},
        '{ROW_ITEM, NO_RESULT,  5'd0,  4'd2,  64'd0,    1'b1, NO_OUT},
        '{ROW_CFG,  NO_RESULT,  5'd31, 4'd0,  64'd0,    1'b0, NO_OUT},
        '{ROW_ITEM, NO_RESULT,  5'd0,  4'd3,  64'd5,    1'b0, NO_OUT}
    };

    // DUT-facing signals; the inputs driven here are known from time zero
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [IDX_W-1:0]   run_index = '0;
    logic [WORD_W-1:0]  word_value = '0;
    logic               run_end = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [WORD_W-1:0]  min_value;
    logic [IDX_W-1:0]   source_run;
    logic               merge_done;

    k_way_sorted_run_merger dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_run_index  (run_index),
        .i_word_value (word_value),
        .i_run_end    (run_end),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_min_value  (min_value),
        .o_source_run (source_run),
        .o_merge_done (merge_done)
    );

    // Predictor state: the run count register and one head slot per run
    logic [CFG_W-1:0]  merge_ways = 5'd16;
    logic [WORD_W-1:0] head [RUNS];
    bit                held [RUNS];
    bit                closed [RUNS];
    bit [WORD_W-1:0]   last_word [RUNS];   // per-run seed for ascending words

    t_merge_out merged_due [$];            // results still to come, oldest first
    int         fail_count = 0;
    int         stall_left = 0;
    bit         bursts_on = 1'b1;          // random idling on both sides

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        if (fail_count < PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $time, msg);
        fail_count++;
    endtask

    // append one expected result behind the ones still pending
    function automatic void queue_due(input t_merge_out res);
        merged_due = {merged_due, res};
    endfunction

    // effective count: zero means one run, anything above RUNS saturates
    function automatic int live_runs();
        int n = merge_ways;
        if (n == 0)
            n = 1;
        if (n > RUNS)
            n = RUNS;
        return n;
    endfunction

    function automatic int open_runs();
        int cnt = 0;
        for (int r = 0; r < RUNS; r++)
            if (!closed[r])
                cnt++;
        return cnt;
    endfunction

    function automatic bit all_live_closed();
        for (int r = 0; r < live_runs(); r++)
            if (!closed[r])
                return 1'b0;
        return 1'b1;
    endfunction

    // One transfer into the merge: refill or close a run, then emit the
    // smallest head (lowest run on a tie) once every live run is full or
    // closed. Done only on the end marker that closes the last live run.
    task automatic predict_merge(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] word,
                                 input logic last, output bit took, output bit fired,
                                 output t_merge_out res);
        int n, best;
        bit ready, any_held, every_closed, closed_now;
        n = live_runs();
        best = -1;
        ready = 1'b1;
        any_held = 1'b0;
        every_closed = 1'b1;
        closed_now = 1'b0;
        took = 1'b0;
        fired = 1'b0;
        res = '0;
        if (idx < n && !held[idx] && !closed[idx]) begin
            took = 1'b1;
            if (last) begin
                closed[idx] = 1'b1;
                closed_now = 1'b1;
            end else begin
                head[idx] = word;
                held[idx] = 1'b1;
            end
        end
        for (int r = 0; r < n; r++) begin
            if (held[r]) begin
                any_held = 1'b1;
                every_closed = 1'b0;
                if (best < 0 || head[r] < head[best])
                    best = r;
            end else if (!closed[r]) begin
                ready = 1'b0;
                every_closed = 1'b0;
            end
        end
        if (ready && any_held) begin
            res.value = head[best];
            res.src = IDX_W'(best);
            held[best] = 1'b0;
            fired = 1'b1;
        end else if (closed_now && every_closed) begin
            res.done = 1'b1;
            fired = 1'b1;
        end
    endtask

    // Mostly ascending words per run, with ties, full-range values and extremes
    function automatic logic [WORD_W-1:0] next_word(input logic [IDX_W-1:0] r);
        logic [WORD_W-1:0] w;
        case ($urandom_range(0, 9))
            6: w = WORD_W'($urandom_range(0, 3));
            7, 8: w = {$urandom, $urandom};
            9: w = $urandom_range(0, 1) ? WORD_MAX : '0;
            default: begin
                if (last_word[r] > WORD_MAX - 64'd1000)
                    w = {$urandom, $urandom};
                else
                    w = last_word[r] + $urandom_range(0, 999);
            end
        endcase
        last_word[r] = w;
        return w;
    endfunction

    // Hold the input side until every pending result is out and the block
    // has had time to return to idle after a transfer that produces nothing.
    task automatic settle();
        in_valid <= 1'b0;
        while (merged_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_run_count(input logic [CFG_W-1:0] cnt);
        settle();
        cfg_we <= 1'b1;
        cfg_data <= cnt;
        @(posedge clk);
        cfg_we <= 1'b0;
        merge_ways = cnt;
    endtask

    // Drive one transfer and wait for it to be taken. Valid only drops here
    // for an idle gap, never in the step where it is raised again.
    task automatic send_item(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] word,
                             input logic last, input t_row_check check,
                             input t_merge_out typed, output bit took);
        bit fired;
        t_merge_out res;
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        run_index <= idx;
        word_value <= word;
        run_end <= last;
        do
            @(posedge clk);
        while (in_stall);
        predict_merge(idx, word, last, took, fired, res);
        case (check)
            BY_MODEL: begin
                if (fired)
                    queue_due(res);
            end
            ONE_RESULT: queue_due(typed);
            default: ;
        endcase
    endtask

    // Random merge phase. Most transfers refill a run the block is waiting
    // on; the rest are noise (inactive, full or closed runs, stray ends).
    // Outside the closing phase only runs 10 and up may end, so the low runs
    // keep every phase busy. The closing phase ends runs freely until done.
    task automatic merge_phase(input logic [CFG_W-1:0] cnt, input int quota,
                               input bit closing);
        int useful, tries, n;
        int waiting [$];
        logic [IDX_W-1:0] idx;
        logic [WORD_W-1:0] w;
        logic last;
        bit took, harmless;
        set_run_count(cnt);
        useful = 0;
        tries = 0;
        while ((closing ? !all_live_closed() : useful < quota) && tries < 4 * quota) begin
            n = live_runs();
            waiting.delete();
            for (int r = 0; r < n; r++)
                if (!held[r] && !closed[r])
                    waiting = {waiting, r};
            if (waiting.size() != 0 && $urandom_range(0, 9) < 8) begin
                idx = IDX_W'(waiting[$urandom_range(0, waiting.size() - 1)]);
                w = next_word(idx);
                if (closing)
                    last = ($urandom_range(0, 5) == 0);
                else
                    last = idx >= 10 && open_runs() > 4 && $urandom_range(0, 99) == 0;
            end else begin
                idx = IDX_W'($urandom_range(0, RUNS - 1));
                w = {$urandom, $urandom};
                last = ($urandom_range(0, 3) == 0);
                harmless = idx >= n || held[idx] || closed[idx];
                if (last && !closing && !harmless && (idx < 10 || open_runs() <= 4))
                    last = 1'b0;
            end
            send_item(idx, w, last, BY_MODEL, NO_OUT, took);
            if (took)
                useful++;
            tries++;
            // now and then drain completely before the next transfer
            if (!closing && $urandom_range(0, 149) == 0)
                settle();
        end
    endtask

    // Output side: random stall bursts, only while bursts are on
    always @(posedge clk) begin
        if (stall_left == 0 && bursts_on && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 3);
        if (stall_left != 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Every result transfer is matched against the oldest expectation
    always @(posedge clk) begin
        t_merge_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (merged_due.size() == 0) begin
                note_mismatch($sformatf("unexpected result value=%h run=%0d done=%b",
                                        min_value, source_run, merge_done));
            end else begin
                want = merged_due.pop_front();
                if (min_value !== want.value)
                    note_mismatch($sformatf("min_value %h, expected %h",
                                            min_value, want.value));
                if (source_run !== want.src)
                    note_mismatch($sformatf("source_run %0d, expected %0d",
                                            source_run, want.src));
                if (merge_done !== want.done)
                    note_mismatch($sformatf("merge_done %b, expected %b",
                                            merge_done, want.done));
            end
        end
    end

    initial begin
        int spin;
        bit took;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < PLAN_LEN; k++) begin
            if (PLAN[k].kind == ROW_CFG)
                set_run_count(PLAN[k].count);
            else
                send_item(PLAN[k].run, PLAN[k].word, PLAN[k].last, PLAN[k].check,
                          PLAN[k].due, took);
        end

        // every third phase runs without idling on either side
        merge_phase(5'd16, 100, 1'b0);
        merge_phase(5'd5, 100, 1'b0);
        bursts_on = 1'b0;
        merge_phase(5'd9, 100, 1'b0);
        bursts_on = 1'b1;
        merge_phase(5'd24, 100, 1'b0);
        merge_phase(5'd4, 100, 1'b0);
        bursts_on = 1'b0;
        merge_phase(5'd13, 100, 1'b0);
        bursts_on = 1'b1;
        merge_phase(CFG_W'($urandom_range(4, 31)), 100, 1'b0);

        // last stretch: no idling, close every run to reach done, then a few
        // transfers that must be ignored
        bursts_on = 1'b0;
        merge_phase(5'd16, 200, 1'b1);
        for (int k = 0; k < 4; k++)
            send_item(IDX_W'($urandom_range(0, RUNS - 1)), {$urandom, $urandom},
                      1'($urandom_range(0, 1)), BY_MODEL, NO_OUT, took);

        in_valid <= 1'b0;
        for (spin = 0; spin < 20000 && merged_due.size() != 0; spin++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (merged_due.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", merged_due.size()));

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
